// File: design/usbc_pkg.sv
// Shared types and constants of the UDP segment batch coalescer.
`default_nettype none

package usbc_pkg;

    localparam int MAX_BATCH = 64;
    localparam int IDX_W     = $clog2(MAX_BATCH);
    localparam int CNT_W     = IDX_W + 1;

    // Largest payload a segmented message may carry.
    localparam logic [16:0] GSO_PAYLOAD_MAX = 17'd65487;
    localparam logic [CNT_W-1:0] MIN_GROUP  = CNT_W'(3);
    localparam logic [CNT_W-1:0] BATCH_FULL = CNT_W'(MAX_BATCH);

    // Configuration register indexes.
    localparam logic CFG_COALESCE_ENABLE = 1'b0;
    localparam logic CFG_MAX_SEGMENTS    = 1'b1;
    localparam int   CFG_DATA_W          = 7;

    typedef struct packed {
        logic        seg_eligible;
        logic [7:0]  path_id;
        logic [1:0]  ecn_mark;
        logic [31:0] buf_addr;
        logic [15:0] dgram_len;
        logic [15:0] link_mtu;
        logic        batch_last;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0] first_index;
        logic [CNT_W-1:0] end_index;
        logic [31:0]      msg_addr;
        logic [15:0]      msg_len;
        logic [15:0]      segment_size;
        logic [1:0]       msg_ecn;
        logic             msg_last;
    } t_out_word;

    // Per-datagram attributes kept in the batch store.
    typedef struct packed {
        logic       can_start;
        logic [1:0] ecn;
        logic [7:0] path;
        logic       eligible;
    } t_attr;

endpackage

`default_nettype wire

// File: design/usbc_if.sv
// Valid/ready channel interfaces for the descriptor input and message output.
`default_nettype none

interface usbc_in_if;
    logic              valid;
    logic              ready;
    usbc_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface usbc_out_if;
    logic               valid;
    logic               ready;
    usbc_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/udp_segment_batch_coalescer.sv
// Top level of the UDP segment batch coalescer: batch store, scan sequencer, output register.
`default_nettype none

// The block takes a batch of datagram descriptors, one word per cycle while it
// is loading, into an on-chip store of 64 entries. The batch closes on a word
// with batch_last set or when the 64th word arrives; the input then stops
// accepting and a small sequencer walks the stored batch through a single read
// port, emitting one message word per group in batch order. For each message
// the sequencer takes its first descriptor (S_FIRST), tests each following
// datagram for joining, those that join and the one that fails the test
// (S_JOIN), and hands the message to the output register (S_EMIT); each batch
// starts its scan in S_START, and S_EMIT waits while the output register is
// still held by the receiver. The single store read port sets the pace of the
// scan. The output register lets the last message of a batch wait while the
// next batch loads.
// Configuration writes must only happen while the block is idle.

module udp_segment_batch_coalescer (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic                            i_cfg_idx,
    input  wire logic [usbc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    usbc_in_if.sink                              i_in,
    usbc_out_if.source                           o_out
);

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_FIRST = 3'd2;
    localparam logic [2:0] S_JOIN  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    localparam int IW = usbc_pkg::IDX_W;
    localparam int CW = usbc_pkg::CNT_W;

    // Batch store: three memories sharing one write and one read address.
    logic [31:0]         addr_store [usbc_pkg::MAX_BATCH];
    logic [15:0]         len_store  [usbc_pkg::MAX_BATCH];
    usbc_pkg::t_attr     attr_store [usbc_pkg::MAX_BATCH];

    logic [2:0]          r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [CW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_end, n_end;
    logic [15:0]         r_total, n_total;
    logic [15:0]         r_flen, n_flen;
    logic [31:0]         r_faddr, n_faddr;
    usbc_pkg::t_attr     r_fattr, n_fattr;
    logic                r_enable;
    logic [CW-1:0]       r_maxseg;

    logic [31:0]         r_rd_addr;
    logic [15:0]         r_rd_len;
    usbc_pkg::t_attr     r_rd_attr;
    logic [IW-1:0]       rd_sel;

    logic                r_out_valid, n_out_valid;
    usbc_pkg::t_out_word r_out_data, n_out_data;

    logic                in_fire;
    logic                wr_start;
    usbc_pkg::t_attr     wr_attr;
    logic [CW-1:0]       cnt_inc;
    logic                out_free;
    logic                emit_fire;
    logic [CW-1:0]       grp_size;
    logic                coalesced;
    logic [CW-1:0]       out_end;
    logic [CW-1:0]       end_inc;
    logic [CW-1:0]       idx_inc;
    logic [16:0]         sum_len;
    logic                join_ok;
    logic                join_more;

    assign i_in.ready  = (r_state == S_LOAD);
    assign in_fire     = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;
    assign out_free    = !r_out_valid || o_out.ready;
    assign emit_fire   = (r_state == S_EMIT) && out_free;

    // An eligible nonzero datagram filling its MTU within the payload cap can open a group.
    assign wr_start = i_in.data.seg_eligible
                   && (i_in.data.dgram_len == i_in.data.link_mtu)
                   && (i_in.data.dgram_len != 16'd0)
                   && ({1'b0, i_in.data.dgram_len} <= usbc_pkg::GSO_PAYLOAD_MAX);

    always_comb begin
        wr_attr.can_start = wr_start;
        wr_attr.ecn       = i_in.data.ecn_mark;
        wr_attr.path      = i_in.data.path_id;
        wr_attr.eligible  = i_in.data.seg_eligible;
    end

    assign cnt_inc = r_cnt + CW'(1);
    assign idx_inc = r_idx + CW'(1);
    assign end_inc = r_end + CW'(1);

    assign grp_size  = r_end - r_idx;
    assign coalesced = (grp_size >= usbc_pkg::MIN_GROUP);
    assign out_end   = coalesced ? r_end : idx_inc;

    // Join test for the descriptor just read at r_end. The candidate must
    // continue the payload of the group without a gap and keep it in budget.
    assign sum_len = {1'b0, r_total} + {1'b0, r_rd_len};
    assign join_ok = r_rd_attr.eligible
                  && (r_rd_attr.path == r_fattr.path)
                  && (r_rd_attr.ecn == r_fattr.ecn)
                  && (r_rd_addr == r_faddr + {16'd0, r_total})
                  && (r_rd_len <= r_flen)
                  && (sum_len <= usbc_pkg::GSO_PAYLOAD_MAX);
    // A full-size joiner lets the group grow further if the batch and the
    // segment limit allow another datagram.
    assign join_more = (r_rd_len == r_flen)
                    && (end_inc < r_cnt)
                    && ((end_inc - r_idx) < r_maxseg);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_end       = r_end;
        n_total     = r_total;
        n_flen      = r_flen;
        n_faddr     = r_faddr;
        n_fattr     = r_fattr;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_data  = r_out_data;
        rd_sel      = '0;

        case (r_state)
            S_LOAD: begin
                if (in_fire) begin
                    n_cnt = cnt_inc;
                    if (i_in.data.batch_last || cnt_inc == usbc_pkg::BATCH_FULL) begin
                        n_idx   = '0;
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                // Fetch the first descriptor of the batch.
                rd_sel  = '0;
                n_state = S_FIRST;
            end
            S_FIRST: begin
                n_flen  = r_rd_len;
                n_faddr = r_rd_addr;
                n_fattr = r_rd_attr;
                n_total = r_rd_len;
                n_end   = idx_inc;
                rd_sel  = idx_inc[IW-1:0];
                if (r_enable && r_rd_attr.can_start && (idx_inc < r_cnt)
                        && (CW'(1) < r_maxseg)) begin
                    n_state = S_JOIN;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_JOIN: begin
                rd_sel = end_inc[IW-1:0];
                if (join_ok) begin
                    n_total = sum_len[15:0];
                    n_end   = end_inc;
                    n_state = join_more ? S_JOIN : S_EMIT;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                rd_sel = out_end[IW-1:0];
                if (out_free) begin
                    n_out_valid              = 1'b1;
                    n_out_data.first_index   = r_idx[IW-1:0];
                    n_out_data.end_index     = out_end;
                    n_out_data.msg_addr      = r_faddr;
                    n_out_data.msg_len       = coalesced ? r_total : r_flen;
                    n_out_data.segment_size  = coalesced ? r_flen : 16'd0;
                    n_out_data.msg_ecn       = r_fattr.ecn;
                    n_out_data.msg_last      = (out_end >= r_cnt);
                    n_idx                    = out_end;
                    if (out_end >= r_cnt) begin
                        n_cnt   = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_FIRST;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_enable    <= 1'b1;
            r_maxseg    <= CW'(usbc_pkg::MAX_BATCH);
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    usbc_pkg::CFG_COALESCE_ENABLE: r_enable <= i_cfg_data[0];
                    usbc_pkg::CFG_MAX_SEGMENTS:    r_maxseg <= i_cfg_data[CW-1:0];
                    default:                       r_enable <= r_enable;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_end      <= n_end;
        r_total    <= n_total;
        r_flen     <= n_flen;
        r_faddr    <= n_faddr;
        r_fattr    <= n_fattr;
        r_out_data <= n_out_data;
    end

    // Store write port: the slot is the running count within the batch.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            addr_store[r_cnt[IW-1:0]] <= i_in.data.buf_addr;
            len_store[r_cnt[IW-1:0]]  <= i_in.data.dgram_len;
            attr_store[r_cnt[IW-1:0]] <= wr_attr;
        end
    end

    // Store read port with registered data.
    always_ff @(posedge i_clk) begin
        r_rd_addr <= addr_store[rd_sel];
        r_rd_len  <= len_store[rd_sel];
        r_rd_attr <= attr_store[rd_sel];
    end

    // The batch count never runs past the store depth.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= usbc_pkg::BATCH_FULL)
        else $error("batch count exceeds store depth");

    // While a group grows, the candidate always lies inside the batch.
    a_join_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_JOIN) |-> (r_end < r_cnt) && (r_end > r_idx))
        else $error("join candidate outside the batch");

    // A message handed over shows up on the output in the next cycle.
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_fire |=> o_out.valid)
        else $error("emitted message not presented");

    // A segmented message spans at least the minimum group size.
    a_seg_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.data.segment_size != 16'd0))
            |-> ((o_out.data.end_index - {1'b0, o_out.data.first_index})
                 >= usbc_pkg::MIN_GROUP))
        else $error("segmented message with too few datagrams");

    // A single message always covers exactly one datagram.
    a_single_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.data.segment_size == 16'd0))
            |-> ((o_out.data.end_index - {1'b0, o_out.data.first_index}) == CW'(1)))
        else $error("single message spans several datagrams");

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the UDP segment batch coalescer: directed batches, then random ones.

// The testbench loads batches of datagram descriptors into the block, one word per
// handshake. It keeps its own copy of the batch store and of the two configuration
// registers. When a word closes a batch, either by batch_last or because the store
// is full, it groups the stored batch into send messages and queues them as the
// expected results (a typed row queues its own message). Every message word that
// leaves the block is compared field by field with the oldest queued expectation.
module testbench;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 5;
    // Pause after the last expected word has left, before any configuration write
    // or the end.
    localparam int SETTLE_CYCLES = 16;
    // The longest correct stretch without any handshake is the scan of one long
    // group on top of a receiver stall, or the pause above plus the configuration
    // writes. The limit is far beyond either.
    localparam int STALL_LIMIT   = 1000;
    localparam int MAX_REPORTS   = 10;
    // Random words per configuration phase; seven phases give at least 336 words.
    localparam int PHASE_WORDS   = 48;
    localparam int IW            = usbc_pkg::IDX_W;
    localparam int CW            = usbc_pkg::CNT_W;
    localparam int CFG_W         = usbc_pkg::CFG_DATA_W;

    // Ways in which a random group is broken partway through.
    typedef enum int {
        BREAK_INELIGIBLE = 0,
        BREAK_PATH       = 1,
        BREAK_ECN        = 2,
        BREAK_GAP        = 3,
        BREAK_LONGER     = 4
    } t_break_kind;

    // One row of the directed table. Where typed is set, msg holds the expected
    // message written out by hand; otherwise the grouping model decides.
    typedef struct {
        usbc_pkg::t_in_word  word;
        bit                  typed;
        usbc_pkg::t_out_word msg;
    } t_stim_row;

    typedef struct {
        bit          write_cfg;
        bit          enable;
        int unsigned max_segs;
        bit          steady;
    } t_phase;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic             cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    usbc_in_if  in_ch ();
    usbc_out_if out_ch ();

    udp_segment_batch_coalescer dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Local copy of the batch store and the configuration.
    logic [31:0]     batch_addr [usbc_pkg::MAX_BATCH];
    logic [15:0]     batch_len  [usbc_pkg::MAX_BATCH];
    usbc_pkg::t_attr batch_attr [usbc_pkg::MAX_BATCH];
    int unsigned     batch_fill;
    bit              cfg_coalesce;
    int unsigned     cfg_max_segs;

    // Messages produced by the latest batch close, and all messages still owed.
    usbc_pkg::t_out_word scanned_msgs [$];
    usbc_pkg::t_out_word expected_msgs [$];

    // Directed stimulus table.
    t_stim_row   rows [$];

    int unsigned mismatches;
    int unsigned quiet_cycles;
    // While set, neither the sender nor the receiver inserts idle cycles.
    bit          steady_flow;

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // Walk the stored batch in order and emit one message per group. A group
    // starts only at a word marked as a possible start; it grows while the next
    // word is eligible, on the same path and ECN, follows on in memory, is no
    // longer than the first, keeps the total within the payload cap and stays
    // within the segment limit. A shorter word joins and closes the group.
    // Groups of fewer than three fall back to a single message for their first word.
    function automatic void group_batch();
        int unsigned         idx;
        int unsigned         stop;
        int unsigned         total;
        int unsigned         lead_len;
        logic [31:0]         next_addr;
        usbc_pkg::t_attr     lead;
        usbc_pkg::t_out_word m;
        idx = 0;
        while (idx < batch_fill) begin
            lead     = batch_attr[idx];
            lead_len = batch_len[idx];
            stop     = idx + 1;
            total    = lead_len;
            if (cfg_coalesce && lead.can_start) begin
                while (stop < batch_fill && stop - idx < cfg_max_segs) begin
                    next_addr = batch_addr[idx] + total;
                    if (!batch_attr[stop].eligible ||
                        batch_attr[stop].path != lead.path ||
                        batch_attr[stop].ecn != lead.ecn ||
                        batch_addr[stop] != next_addr ||
                        batch_len[stop] > lead_len ||
                        batch_len[stop] > usbc_pkg::GSO_PAYLOAD_MAX - total)
                        break;
                    total = total + batch_len[stop];
                    stop  = stop + 1;
                    if (batch_len[stop-1] < lead_len)
                        break;
                end
            end
            if (stop - idx < usbc_pkg::MIN_GROUP) begin
                stop           = idx + 1;
                m.msg_len      = lead_len[15:0];
                m.segment_size = '0;
            end else begin
                m.msg_len      = total[15:0];
                m.segment_size = lead_len[15:0];
            end
            m.first_index = IW'(idx);
            m.end_index   = CW'(stop);
            m.msg_addr    = batch_addr[idx];
            m.msg_ecn     = lead.ecn;
            m.msg_last    = (stop >= batch_fill);
            scanned_msgs.insert(scanned_msgs.size(), m);
            idx = stop;
        end
        batch_fill = 0;
    endfunction

    // Store one accepted descriptor; a last flag or a full store closes the batch.
    function automatic void store_descriptor(usbc_pkg::t_in_word w);
        usbc_pkg::t_attr a;
        a.eligible  = w.seg_eligible;
        a.path      = w.path_id;
        a.ecn       = w.ecn_mark;
        a.can_start = w.seg_eligible && w.dgram_len == w.link_mtu &&
                      w.dgram_len != 16'd0 && w.dgram_len <= usbc_pkg::GSO_PAYLOAD_MAX;
        batch_addr[batch_fill] = w.buf_addr;
        batch_len[batch_fill]  = w.dgram_len;
        batch_attr[batch_fill] = a;
        batch_fill = batch_fill + 1;
        if (w.batch_last || batch_fill >= usbc_pkg::MAX_BATCH)
            group_batch();
    endfunction

    function automatic usbc_pkg::t_in_word dgram(bit elig, logic [7:0] path,
                                                 logic [1:0] ecn, logic [31:0] addr,
                                                 logic [15:0] len, logic [15:0] mtu,
                                                 bit last);
        usbc_pkg::t_in_word w;
        w.seg_eligible = elig;
        w.path_id      = path;
        w.ecn_mark     = ecn;
        w.buf_addr     = addr;
        w.dgram_len    = len;
        w.link_mtu     = mtu;
        w.batch_last   = last;
        return w;
    endfunction

    // The message of a batch that holds a single datagram.
    function automatic usbc_pkg::t_out_word single_msg(logic [31:0] addr, logic [15:0] len,
                                                       logic [1:0] ecn);
        usbc_pkg::t_out_word m;
        m.first_index  = '0;
        m.end_index    = CW'(1);
        m.msg_addr     = addr;
        m.msg_len      = len;
        m.segment_size = '0;
        m.msg_ecn      = ecn;
        m.msg_last     = 1'b1;
        return m;
    endfunction

    // Append one row to the directed table.
    function automatic void add_row(usbc_pkg::t_in_word w, bit typed,
                                    usbc_pkg::t_out_word msg);
        t_stim_row r;
        r.word  = w;
        r.typed = typed;
        r.msg   = msg;
        rows.insert(rows.size(), r);
    endfunction

    // Append either a noise word or a run of back-to-back datagrams on one path,
    // sometimes broken partway and sometimes closed by a shorter datagram.
    function automatic void append_group(ref usbc_pkg::t_in_word q[$]);
        usbc_pkg::t_in_word w;
        int unsigned        pick;
        int unsigned        seg;
        int unsigned        run;
        logic [31:0]        addr;
        logic [7:0]         path;
        logic [1:0]         ecn;
        pick = $urandom_range(99);
        if (pick < 20) begin
            w.seg_eligible = 1'($urandom_range(1));
            w.path_id      = 8'($urandom_range(255));
            w.ecn_mark     = 2'($urandom_range(3));
            w.buf_addr     = $urandom;
            w.dgram_len    = 16'($urandom_range(65535));
            w.link_mtu     = $urandom_range(1) ? w.dgram_len : 16'($urandom_range(65535));
            w.batch_last   = 1'b0;
            q.insert(q.size(), w);
            return;
        end
        path = 8'($urandom_range(255));
        ecn  = 2'($urandom_range(3));
        addr = $urandom;
        pick = $urandom_range(99);
        seg  = (pick < 70) ? $urandom_range(1500, 1) :
               (pick < 90) ? $urandom_range(65535, 1) :
               (pick < 95) ? int'(usbc_pkg::GSO_PAYLOAD_MAX) : 1;
        run  = ($urandom_range(19) == 0) ? $urandom_range(70, 20) : $urandom_range(8, 1);
        for (int i = 0; i < run; i++) begin
            w = dgram(1'b1, path, ecn, addr, seg[15:0], seg[15:0], 1'b0);
            if (i == 0 && $urandom_range(9) == 0)
                w.link_mtu = 16'($urandom_range(65535));
            if (i > 0 && $urandom_range(9) == 0) begin
                case (t_break_kind'($urandom_range(4)))
                    BREAK_INELIGIBLE: w.seg_eligible = 1'b0;
                    BREAK_PATH:       w.path_id = w.path_id ^ 8'(1 << $urandom_range(7));
                    BREAK_ECN:        w.ecn_mark = w.ecn_mark ^ 2'($urandom_range(3, 1));
                    BREAK_GAP:        w.buf_addr = w.buf_addr + 32'd1;
                    default:          w.dgram_len = w.dgram_len + 16'd1;
                endcase
            end
            q.insert(q.size(), w);
            addr = w.buf_addr + w.dgram_len;
        end
        if ($urandom_range(3) == 0) begin
            w = dgram(1'b1, path, ecn, addr, 16'($urandom_range(seg - 1, 0)),
                      16'($urandom_range(65535)), 1'b0);
            q.insert(q.size(), w);
        end
    endfunction

    // Build one batch: mostly short ones, some that fill the store exactly, and a
    // few that run past it so that the store closes itself and a new batch begins.
    function automatic void plan_batch(ref usbc_pkg::t_in_word q[$]);
        int unsigned        pick;
        int unsigned        target;
        usbc_pkg::t_in_word w;
        pick   = $urandom_range(99);
        target = (pick < 85) ? $urandom_range(16, 1) :
                 (pick < 95) ? usbc_pkg::MAX_BATCH : $urandom_range(80, 65);
        q.delete();
        while (q.size() < target)
            append_group(q);
        while (q.size() > target)
            void'(q.pop_back());
        w = q.pop_back();
        w.batch_last = (target == usbc_pkg::MAX_BATCH) ? 1'($urandom_range(1)) : 1'b1;
        q.insert(q.size(), w);
    endfunction

    // Offer one word, with random idle cycles ahead of it, and wait until it is
    // taken. The valid stays high after acceptance so that back-to-back words
    // need only one assignment at the next falling edge.
    task automatic send_dgram(input usbc_pkg::t_in_word w, input bit typed,
                              input usbc_pkg::t_out_word msg);
        while (!steady_flow && $urandom_range(99) < 8) begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        scanned_msgs.delete();
        store_descriptor(w);
        if (typed)
            expected_msgs.insert(expected_msgs.size(), msg);
        else
            foreach (scanned_msgs[i])
                expected_msgs.insert(expected_msgs.size(), scanned_msgs[i]);
    endtask

    // Stop offering words and let every owed message come out, then give the
    // sequencer time to finish before anything else happens.
    task automatic wait_for_idle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (expected_msgs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input bit enable, input int unsigned max_segs);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= usbc_pkg::CFG_COALESCE_ENABLE;
        cfg_data <= CFG_W'(enable);
        @(negedge clk);
        cfg_idx  <= usbc_pkg::CFG_MAX_SEGMENTS;
        cfg_data <= CFG_W'(max_segs);
        @(negedge clk);
        cfg_we   <= 1'b0;
        cfg_coalesce = enable;
        cfg_max_segs = max_segs;
    endtask

    function automatic void check_message(usbc_pkg::t_out_word got);
        usbc_pkg::t_out_word want;
        if (expected_msgs.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("unexpected message: first=%0d end=%0d addr=%h len=%0d",
                         got.first_index, got.end_index, got.msg_addr, got.msg_len);
            return;
        end
        want = expected_msgs.pop_front();
        if (got.first_index !== want.first_index || got.end_index !== want.end_index ||
            got.msg_addr !== want.msg_addr || got.msg_len !== want.msg_len ||
            got.segment_size !== want.segment_size || got.msg_ecn !== want.msg_ecn ||
            got.msg_last !== want.msg_last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display({"message mismatch: expected first=%0d end=%0d addr=%h len=%0d ",
                          "seg=%0d ecn=%0d last=%0d, got first=%0d end=%0d addr=%h ",
                          "len=%0d seg=%0d ecn=%0d last=%0d"},
                         want.first_index, want.end_index, want.msg_addr, want.msg_len,
                         want.segment_size, want.msg_ecn, want.msg_last,
                         got.first_index, got.end_index, got.msg_addr, got.msg_len,
                         got.segment_size, got.msg_ecn, got.msg_last);
        end
    endfunction

    // Receiver: drops ready at random, about eight percent of the time, unless the flow is steady.
    always @(negedge clk)
        out_ch.ready <= steady_flow || ($urandom_range(99) >= 8);

    always @(posedge clk)
        if (rst_n && out_ch.valid && out_ch.ready)
            check_message(out_ch.data);

    // Watchdog: any handshake on either side counts as progress.
    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        t_phase             phases [$];
        usbc_pkg::t_in_word batch [$];
        int unsigned        sent;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = usbc_pkg::CFG_COALESCE_ENABLE;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        steady_flow  = 1'b0;
        batch_fill   = 0;
        cfg_coalesce = 1'b1;
        cfg_max_segs = usbc_pkg::MAX_BATCH;

        // Batches of one datagram: the message is the word itself, whatever the
        // fields hold. These cover the field extremes and a zero length.
        add_row(dgram(1'b0, 8'h00, 2'd0, 32'h0000_0000, 16'd1, 16'd0, 1'b1), 1'b1,
                single_msg(32'h0000_0000, 16'd1, 2'd0));
        add_row(dgram(1'b1, 8'hFF, 2'd3, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1), 1'b1,
                single_msg(32'hFFFF_FFFF, 16'hFFFF, 2'd3));
        add_row(dgram(1'b1, 8'h5A, 2'd1, 32'h8000_0000, 16'd0, 16'd0, 1'b1), 1'b1,
                single_msg(32'h8000_0000, 16'd0, 2'd1));
        add_row(dgram(1'b1, 8'hA5, 2'd2, 32'h1234_5678, 16'd65487, 16'd65487, 1'b1), 1'b1,
                single_msg(32'h1234_5678, 16'd65487, 2'd2));
        // Three full segments make one segmented message.
        add_row(dgram(1'b1, 8'h05, 2'd2, 32'h0000_1000, 16'd1200, 16'd1200, 1'b0), 1'b0, '0);
        add_row(dgram(1'b1, 8'h05, 2'd2, 32'h0000_14B0, 16'd1200, 16'd1200, 1'b0), 1'b0, '0);
        add_row(dgram(1'b1, 8'h05, 2'd2, 32'h0000_1960, 16'd1200, 16'd1200, 1'b1), 1'b0, '0);
        // A shorter datagram closes the group; the one after it stands alone.
        add_row(dgram(1'b1, 8'h11, 2'd0, 32'h0002_0000, 16'd1000, 16'd1000, 1'b0), 1'b0, '0);
        add_row(dgram(1'b1, 8'h11, 2'd0, 32'h0002_03E8, 16'd1000, 16'd1000, 1'b0), 1'b0, '0);
        add_row(dgram(1'b1, 8'h11, 2'd0, 32'h0002_07D0, 16'd500, 16'd500, 1'b0), 1'b0, '0);
        add_row(dgram(1'b1, 8'h11, 2'd0, 32'h0002_09C4, 16'd1000, 16'd1000, 1'b1), 1'b0, '0);
        // The contiguity test wraps around the top of the address space.
        add_row(dgram(1'b1, 8'h77, 2'd3, 32'hFFFF_FC00, 16'd1024, 16'd1024, 1'b0), 1'b0, '0);
        add_row(dgram(1'b1, 8'h77, 2'd3, 32'h0000_0000, 16'd1024, 16'd1024, 1'b0), 1'b0, '0);
        add_row(dgram(1'b1, 8'h77, 2'd3, 32'h0000_0400, 16'd1024, 16'd1024, 1'b1), 1'b0, '0);
        // The group total lands exactly on the payload cap.
        add_row(dgram(1'b1, 8'h20, 2'd1, 32'h0010_0000, 16'd30000, 16'd30000, 1'b0), 1'b0, '0);
        add_row(dgram(1'b1, 8'h20, 2'd1, 32'h0010_7530, 16'd30000, 16'd30000, 1'b0), 1'b0, '0);
        add_row(dgram(1'b1, 8'h20, 2'd1, 32'h0010_EA60, 16'd5487, 16'd5487, 1'b1), 1'b0, '0);
        // One byte over the cap: the pair falls back to single messages.
        add_row(dgram(1'b1, 8'h21, 2'd1, 32'h0020_0000, 16'd30000, 16'd30000, 1'b0), 1'b0, '0);
        add_row(dgram(1'b1, 8'h21, 2'd1, 32'h0020_7530, 16'd30000, 16'd30000, 1'b0), 1'b0, '0);
        add_row(dgram(1'b1, 8'h21, 2'd1, 32'h0020_EA60, 16'd5488, 16'd5488, 1'b1), 1'b0, '0);
        // A zero-length datagram joins as the short one and closes the group.
        add_row(dgram(1'b1, 8'h30, 2'd0, 32'h0030_0000, 16'd800, 16'd800, 1'b0), 1'b0, '0);
        add_row(dgram(1'b1, 8'h30, 2'd0, 32'h0030_0320, 16'd800, 16'd800, 1'b0), 1'b0, '0);
        add_row(dgram(1'b1, 8'h30, 2'd0, 32'h0030_0640, 16'd0, 16'd0, 1'b1), 1'b0, '0);
        // A change of ECN breaks an otherwise good pair.
        add_row(dgram(1'b1, 8'h40, 2'd1, 32'h0040_0000, 16'd1400, 16'd1400, 1'b0), 1'b0, '0);
        add_row(dgram(1'b1, 8'h40, 2'd2, 32'h0040_0578, 16'd1400, 16'd1400, 1'b1), 1'b0, '0);

        // The first phase keeps the reset values; the rest cover grouping off,
        // segment limits of zero, one and three, the full limit with no idling at
        // all, and a random limit.
        phases.insert(phases.size(), '{1'b0, 1'b1, usbc_pkg::MAX_BATCH, 1'b0});
        phases.insert(phases.size(), '{1'b1, 1'b0, usbc_pkg::MAX_BATCH, 1'b0});
        phases.insert(phases.size(), '{1'b1, 1'b1, 0, 1'b0});
        phases.insert(phases.size(), '{1'b1, 1'b1, 1, 1'b0});
        phases.insert(phases.size(), '{1'b1, 1'b1, 3, 1'b0});
        phases.insert(phases.size(), '{1'b1, 1'b1, usbc_pkg::MAX_BATCH, 1'b1});
        phases.insert(phases.size(),
                      '{1'b1, 1'b1, $urandom_range(usbc_pkg::MAX_BATCH - 1, 2), 1'b0});

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
            send_dgram(rows[i].word, rows[i].typed, rows[i].msg);

        foreach (phases[p]) begin
            if (phases[p].write_cfg) begin
                wait_for_idle();
                write_config(phases[p].enable, phases[p].max_segs);
            end
            steady_flow = phases[p].steady;
            sent = 0;
            while (sent < PHASE_WORDS) begin
                plan_batch(batch);
                foreach (batch[i])
                    send_dgram(batch[i], 1'b0, '0);
                sent = sent + batch.size();
            end
        end
        steady_flow = 1'b0;

        wait_for_idle();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
design/usbc_pkg.sv
design/usbc_if.sv
design/udp_segment_batch_coalescer.sv
dv/testbench.sv
